/* hdl/b32gd_pkg.sv */
`default_nettype none
package b32gd_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned ACC_W     = 16;
	localparam int unsigned PEND_W    = 3;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned DATA_W    = 40;
	localparam int unsigned ALPHA_N   = 32;
	localparam int unsigned CFG_N     = 4;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;
	localparam logic [IDX_W-1:0]  NO_MATCH = 6'd32;

	typedef logic [CFG_N-1:0][CFG_W-1:0] alphabet_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
		logic              status;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             pad;
		logic             has;
		logic             eot;
	} item_t;

endpackage
`default_nettype wire

/* hdl/b32gd_lookup.sv */
`default_nettype none
module b32gd_lookup (
	input  wire logic [b32gd_pkg::CHAR_W-1:0] char_code,
	input  wire b32gd_pkg::alphabet_t         alphabet,
	output logic      [b32gd_pkg::IDX_W-1:0]  idx
);

	// lowest matching index wins
	always_comb begin
		idx = b32gd_pkg::NO_MATCH;
		for (int i = b32gd_pkg::ALPHA_N - 1; i >= 0; i--) begin
			if (alphabet[i / 8][(i % 8) * 8 +: 8] == char_code) begin
				idx = b32gd_pkg::IDX_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/b32gd_core.sv */
`default_nettype none
module b32gd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire b32gd_pkg::item_t   item,
	input  wire logic               step,
	output logic                    res_valid,
	output b32gd_pkg::result_t      res
);

	logic [b32gd_pkg::ACC_W-1:0]  acc_q;
	logic [b32gd_pkg::PEND_W-1:0] pend_q;
	logic [b32gd_pkg::POS_W-1:0]  pos_q;
	logic [b32gd_pkg::CNT_W-1:0]  done_q;
	logic [b32gd_pkg::DATA_W-1:0] store_q;
	logic                         skip_q;

	logic [b32gd_pkg::ACC_W-1:0]  acc_n;
	logic [3:0]                   bits_sum;
	logic [b32gd_pkg::PEND_W-1:0] pend_n;
	logic [b32gd_pkg::POS_W-1:0]  pos_n;
	logic [b32gd_pkg::CNT_W-1:0]  done_n;
	logic [b32gd_pkg::DATA_W-1:0] store_n;
	logic [b32gd_pkg::ACC_W-1:0]  acc_sh;
	logic                         finish;
	logic                         by_pad;
	logic                         skip_n;
	logic [b32gd_pkg::POS_W-1:0]  fin_pos;
	logic [b32gd_pkg::CNT_W-1:0]  fin_done;
	logic [b32gd_pkg::DATA_W-1:0] fin_store;
	logic                         len_ok;
	logic [b32gd_pkg::DATA_W-1:0] aligned;

	always_comb begin
		acc_n    = {acc_q[b32gd_pkg::ACC_W-6:0], 5'b0} | b32gd_pkg::ACC_W'(item.idx);
		bits_sum = {1'b0, pend_q} + 4'd5;
		acc_sh   = acc_n >> bits_sum[2:0];
		pend_n   = bits_sum[2:0];
		done_n   = done_q;
		store_n  = store_q;
		if (bits_sum[3]) begin
			store_n = {store_q[b32gd_pkg::DATA_W-9:0], acc_sh[7:0]};
			done_n  = done_q + 3'd1;
		end
		pos_n = pos_q + 4'd1;
	end

	always_comb begin
		finish    = 1'b0;
		by_pad    = 1'b0;
		skip_n    = skip_q;
		fin_pos   = pos_q;
		fin_done  = done_q;
		fin_store = store_q;
		if (skip_q) begin
			if (!item.has || item.eot) begin
				skip_n = 1'b0;
			end
		end else if (!item.has) begin
			finish = 1'b1;
		end else if (item.pad) begin
			finish = 1'b1;
			by_pad = 1'b1;
			skip_n = !item.eot;
		end else begin
			fin_pos   = pos_n;
			fin_done  = done_n;
			fin_store = store_n;
			if (pos_n[3]) begin
				finish = 1'b1;
				skip_n = !item.eot;
			end else if (item.eot) begin
				finish = 1'b1;
			end
		end
	end

	always_comb begin
		len_ok = (fin_pos == 4'd2) || (fin_pos == 4'd4) || (fin_pos == 4'd5) ||
			(fin_pos == 4'd7) || (fin_pos == 4'd8) || ((fin_pos == 4'd0) && !by_pad);
		case (fin_done)
			3'd0:    aligned = '0;
			3'd1:    aligned = {fin_store[7:0], 32'b0};
			3'd2:    aligned = {fin_store[15:0], 24'b0};
			3'd3:    aligned = {fin_store[23:0], 16'b0};
			3'd4:    aligned = {fin_store[31:0], 8'b0};
			3'd5:    aligned = fin_store;
			default: aligned = '0;
		endcase
		res_valid = item_valid && !skip_q && finish;
		if (len_ok && (fin_done <= 3'd5)) begin
			res.data   = aligned;
			res.count  = fin_done;
			res.status = 1'b0;
		end else begin
			res.data   = '0;
			res.count  = '0;
			res.status = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_q  <= '0;
			pos_q   <= '0;
			done_q  <= '0;
			store_q <= '0;
			skip_q  <= 1'b0;
		end else if (step) begin
			skip_q <= skip_n;
			if (finish) begin
				acc_q   <= '0;
				pend_q  <= '0;
				pos_q   <= '0;
				done_q  <= '0;
				store_q <= '0;
			end else if (!skip_q) begin
				acc_q   <= acc_n;
				pend_q  <= pend_n;
				pos_q   <= pos_n;
				done_q  <= done_n;
				store_q <= store_n;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/base32_group_decoder.sv */
// an accepted word passes the input register and then the result register to the master side
// throughput: one character word per cycle; only a stalled result holds the input side
// the alphabet lookup sits before the input register, the group update before the result register
// reset: asynchronous, clears group state, skip flag, alphabet registers and both valid flags
`default_nettype none
module base32_group_decoder (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [b32gd_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [b32gd_pkg::CFG_W-1:0]            pwdata,
	output logic      [b32gd_pkg::CFG_W-1:0]            prdata,
	output logic                                        pready,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [7:0]                             s_tdata,  // char_code
	input  wire logic                                   s_tuser,  // has_char
	input  wire logic                                   s_tlast,  // end_of_text
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic      [b32gd_pkg::OUT_TDATA_W-1:0]      m_tdata,  // decoded_bytes, byte_count, zero fill
	output logic                                        m_tuser   // status
);

	b32gd_pkg::alphabet_t alpha_q;
	b32gd_pkg::item_t     item_s1;
	logic                 valid_s1;
	logic [b32gd_pkg::IDX_W-1:0] idx;
	b32gd_pkg::result_t   res;
	logic                 res_valid;
	b32gd_pkg::result_t   out_q;
	logic                 out_valid_q;
	logic                 advance;

	assign pready = 1'b1;
	assign prdata = alpha_q[paddr[4:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			alpha_q[paddr[4:3]] <= pwdata;
		end
	end

	b32gd_lookup u_lookup (
		.char_code (s_tdata),
		.alphabet  (alpha_q),
		.idx       (idx)
	);

	assign advance  = !valid_s1 || !res_valid || !out_valid_q || m_tready;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.idx <= idx;
			item_s1.pad <= (s_tdata == b32gd_pkg::PAD_CHAR);
			item_s1.has <= s_tuser;
			item_s1.eot <= s_tlast;
		end
	end

	b32gd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.step       (valid_s1 && advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.count, out_q.data};
	assign m_tuser  = out_q.status;

endmodule
`default_nettype wire

/* sim/tb_base32_group_decoder.sv */
module tb_base32_group_decoder;
	import b32gd_pkg::*;

	localparam int          IDLE_PCT     = 16;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 4;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic        STATUS_OK    = 1'b0;
	localparam logic        STATUS_BAD   = 1'b1;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              has;
		logic              eot;
	} text_word_t;

	typedef enum int {END_ON_LAST, END_NO_CHAR, END_ON_PAD} group_end_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   psel      = 1'b0;
	logic                   penable   = 1'b0;
	logic                   pwrite    = 1'b0;
	logic [ADDR_W-1:0]      paddr     = '0;
	logic [CFG_W-1:0]       pwdata    = '0;
	logic [CFG_W-1:0]       prdata;
	logic                   pready;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;  // char_code
	logic                   s_tuser   = 1'b0;  // has_char
	logic                   s_tlast   = 1'b0;  // end_of_text
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // decoded_bytes, byte_count, zero fill
	logic                   m_tuser;  // status

	base32_group_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// decoder state mirror
	alphabet_t           alpha_regs  = '0;
	logic [ACC_W-1:0]    grp_acc     = '0;
	logic [PEND_W-1:0]   grp_pend    = '0;
	logic [POS_W-1:0]    grp_pos     = '0;
	logic [CNT_W-1:0]    grp_nbytes  = '0;
	logic [DATA_W-1:0]   grp_store   = '0;
	logic                skip_rest   = 1'b0;

	result_t             expected_groups[$];
	text_word_t          char_feed[$];

	int  errors          = 0;
	int  words_taken     = 0;
	int  groups_seen     = 0;
	int  groups_rejected = 0;
	int  cycles          = 0;
	int  hold_left       = 0;
	logic no_idle        = 1'b0;
	logic hold_go        = 1'b0;
	logic hold_used      = 1'b0;

	function automatic logic [CHAR_W-1:0] alpha_char(int idx);
		return alpha_regs[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	function automatic void close_group(bit by_pad);
		result_t    r;
		logic [79:0] wide;
		bit         ok;
		ok = (grp_pos == 2 || grp_pos == 4 || grp_pos == 5 || grp_pos == 7 ||
			grp_pos == 8 || (grp_pos == 0 && !by_pad));
		if (ok && grp_nbytes <= 5) begin
			wide = {40'b0, grp_store} << (8 * (5 - grp_nbytes));
			r.data = wide[DATA_W-1:0];
			r.count = grp_nbytes;
			r.status = STATUS_OK;
		end else begin
			r = '0;
			r.status = STATUS_BAD;
		end
		expected_groups.push_back(r);
		grp_acc = '0;
		grp_pend = '0;
		grp_pos = '0;
		grp_nbytes = '0;
		grp_store = '0;
	endfunction

	function automatic void absorb_word(text_word_t w);
		logic [IDX_W-1:0] idx;
		int               bits;
		if (skip_rest) begin
			if (!w.has || w.eot)
				skip_rest = 1'b0;
			return;
		end
		if (!w.has) begin
			close_group(1'b0);
			return;
		end
		if (w.code == PAD_CHAR) begin
			close_group(1'b1);
			skip_rest = !w.eot;
			return;
		end
		// lowest matching index wins
		idx = NO_MATCH;
		for (int i = ALPHA_N - 1; i >= 0; i--)
			if (alpha_char(i) == w.code)
				idx = IDX_W'(i);
		grp_acc = (grp_acc << 5) | ACC_W'(idx);
		bits = grp_pend + 5;
		if (bits >= 8) begin
			bits -= 8;
			grp_store = {grp_store[DATA_W-9:0], 8'(grp_acc >> bits)};
			grp_nbytes++;
		end
		grp_pend = PEND_W'(bits);
		grp_pos++;
		if (grp_pos >= 8) begin
			close_group(1'b0);
			skip_rest = !w.eot;
		end else if (w.eot) begin
			close_group(1'b0);
		end
	endfunction

	// sender
	always @(posedge clk) begin : char_driver
		text_word_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				absorb_word({s_tdata, s_tuser, s_tlast});
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (char_feed.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					w = char_feed.pop_front();
					s_tdata <= w.code;
					s_tuser <= w.has;
					s_tlast <= w.eot;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_go && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : group_monitor
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_groups.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: data %h count %0d status %b", $time,
					m_tdata[DATA_W-1:0], m_tdata[DATA_W+CNT_W-1:DATA_W], m_tuser);
			end else begin
				want = expected_groups.pop_front();
				groups_seen++;
				if (want.status == STATUS_BAD)
					groups_rejected++;
				if (m_tdata[DATA_W-1:0] !== want.data) begin
					errors++;
					$display("%0t: decoded bytes expected %h actual %h", $time, want.data,
						m_tdata[DATA_W-1:0]);
				end
				if (m_tdata[DATA_W+CNT_W-1:DATA_W] !== want.count) begin
					errors++;
					$display("%0t: byte count expected %0d actual %0d", $time, want.count,
						m_tdata[DATA_W+CNT_W-1:DATA_W]);
				end
				if (m_tdata[OUT_TDATA_W-1:DATA_W+CNT_W] !== '0) begin
					errors++;
					$display("%0t: fill bits expected 0 actual %h", $time,
						m_tdata[OUT_TDATA_W-1:DATA_W+CNT_W]);
				end
				if (m_tuser !== want.status) begin
					errors++;
					$display("%0t: status expected %b actual %b", $time, want.status, m_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("base32_group_decoder verification failed");
			$finish;
		end
	end

	function automatic void feed(logic [CHAR_W-1:0] c, logic h, logic e);
		char_feed.push_back('{c, h, e});
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char();
		if ($urandom_range(99) < 88)
			return alpha_char($urandom_range(ALPHA_N - 1));
		return CHAR_W'($urandom);
	endfunction

	function automatic alphabet_t pack_alphabet(string s);
		alphabet_t a;
		for (int i = 0; i < ALPHA_N; i++)
			a[i / 8][(i % 8) * 8 +: 8] = s[i];
		return a;
	endfunction

	// one group with random content, mostly of a legal length
	function automatic void make_group();
		int         lens[5] = '{2, 4, 5, 7, 8};
		int         n;
		int         pads;
		group_end_t kind;
		bit         last_eot;
		n = ($urandom_range(9) < 8) ? lens[$urandom_range(4)] : $urandom_range(8);
		if (n == 8) begin
			last_eot = $urandom_range(1);
			for (int i = 0; i < 8; i++)
				feed(pick_char(), 1'b1, last_eot && i == 7);
			if (!last_eot) begin
				repeat ($urandom_range(2))
					feed(CHAR_W'($urandom), 1'b1, 1'b0);
				if ($urandom_range(1))
					feed(CHAR_W'($urandom), 1'b1, 1'b1);
				else
					feed(CHAR_W'($urandom), 1'b0, 1'($urandom));
			end
			return;
		end
		kind = group_end_t'($urandom_range(2));
		if (n == 0 && kind == END_ON_LAST)
			kind = END_NO_CHAR;
		for (int i = 0; i < n; i++)
			feed(pick_char(), 1'b1, kind == END_ON_LAST && i == n - 1);
		if (kind == END_NO_CHAR) begin
			feed(CHAR_W'($urandom), 1'b0, 1'($urandom));
		end else if (kind == END_ON_PAD) begin
			pads = 8 - n;
			for (int i = 0; i < pads; i++)
				feed(PAD_CHAR, 1'b1, i == pads - 1);
		end
	endfunction

	// wait until quiet on consecutive edges: nothing queued, offered, pending or shown
	task automatic wait_idle();
		int quiet;
		quiet = 0;
		while (quiet < DRAIN_CYCLES) begin
			@(posedge clk);
			if (char_feed.size() != 0 || s_tvalid || m_tvalid || expected_groups.size() != 0)
				quiet = 0;
			else
				quiet++;
		end
	endtask

	task automatic run_random(int n);
		int queued;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(99) < 80) begin
				queued -= char_feed.size();
				make_group();
				queued += char_feed.size();
			end else begin
				repeat ($urandom_range(1, 3)) begin
					feed(CHAR_W'($urandom), $urandom_range(9) != 0, $urandom_range(5) == 0);
					queued++;
				end
			end
		end
		wait_idle();
	endtask

	task automatic apb_write(int idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		alpha_regs[idx] = v;
	endtask

	task automatic write_alphabet(alphabet_t a);
		for (int w = 0; w < CFG_N; w++)
			apb_write(w, a[w]);
	endtask

	task automatic directed_words();
		string s;
		s = "MZXW6YTB";
		// flush whatever state the previous setting left
		feed(8'h00, 1'b0, 1'b0);
		feed(8'h00, 1'b0, 1'b1);
		feed(PAD_CHAR, 1'b1, 1'b1);
		feed("M", 1'b1, 1'b0);
		feed("Y", 1'b1, 1'b1);
		feed("M", 1'b1, 1'b0);
		feed("Z", 1'b1, 1'b0);
		feed("X", 1'b1, 1'b0);
		feed("W", 1'b1, 1'b0);
		feed(PAD_CHAR, 1'b1, 1'b0);
		feed(PAD_CHAR, 1'b1, 1'b1);
		feed("M", 1'b1, 1'b1);
		feed("M", 1'b1, 1'b0);
		feed("Z", 1'b1, 1'b0);
		feed("X", 1'b1, 1'b0);
		feed(8'hff, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++)
			feed(s[i], 1'b1, 1'b0);
		feed(8'hff, 1'b1, 1'b0);
		feed(8'h00, 1'b1, 1'b1);
		feed(8'hff, 1'b1, 1'b0);
		feed(8'h80, 1'b1, 1'b1);
		wait_idle();
	endtask

	initial begin
		alphabet_t a;
		int        k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_alphabet('0);
		run_random(50);

		write_alphabet(pack_alphabet("ABCDEFGHIJKLMNOPQRSTUVWXYZ234567"));
		directed_words();
		no_idle <= 1'b1;
		run_random(120);
		no_idle <= 1'b0;
		wait_idle();

		write_alphabet('1);
		run_random(50);

		// output held off while the sender keeps going
		write_alphabet(pack_alphabet("0123456789ABCDEFGHIJKLMNOPQRSTUV"));
		hold_go <= 1'b1;
		run_random(100);

		repeat (3) begin
			for (int w = 0; w < CFG_N; w++)
				a[w] = {$urandom, $urandom};
			k = $urandom_range(ALPHA_N - 1);
			a[k / 8][(k % 8) * 8 +: 8] = PAD_CHAR;
			write_alphabet(a);
			run_random(60);
		end

		$display("%0d characters decoded into %0d groups, %0d of them rejected,", words_taken,
			groups_seen, groups_rejected);
		$display("under zero, all-ones, standard, hex and random alphabets with a long stall");
		if (errors == 0)
			$display("base32_group_decoder verification clean");
		else
			$display("base32_group_decoder verification failed");
		$finish;
	end

endmodule

/* files.f */
hdl/b32gd_pkg.sv
hdl/b32gd_lookup.sv
hdl/b32gd_core.sv
hdl/base32_group_decoder.sv
sim/tb_base32_group_decoder.sv
